@@ rtl/smd_pkg.sv @@
// Shared types and codes for the SHA-1 message digest unit.
`timescale 1ns / 1ps
package smd_pkg;

   localparam logic KIND_APPEND = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   localparam logic [2:0] LAST_INDEX = 3'd4;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } smd_req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } smd_rsp_type;

endpackage

@@ rtl/smd_queue.sv @@
// Front end: small request queue between the input port and the hash core.
`timescale 1ns / 1ps
module smd_queue
   import smd_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  smd_req_type req_data,
   output logic        deq_valid,
   input  logic        deq_ready,
   output smd_req_type deq_data
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   smd_req_type            slot_ff [DEPTH];
   logic [IDX_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   push, pop;

   assign req_ready = (count_ff != CNT_W'(DEPTH));
   assign deq_valid = (count_ff != '0);
   assign deq_data  = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = deq_valid && deq_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

@@ rtl/smd_core.sv @@
// Back end: block buffer, padding sequencer, 80-round compression and digest output.
`timescale 1ns / 1ps
module smd_core
   import smd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        deq_valid,
   output logic        deq_ready,
   input  smd_req_type deq_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output smd_rsp_type rsp_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } state_type;

   localparam logic [4:0][31:0] IV_WORDS = {
      32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
   };
   localparam logic [5:0] BLOCK_LAST_BYTE = 6'd63;
   localparam logic [5:0] LENGTH_OFFSET   = 6'd56;
   localparam logic [6:0] LAST_ROUND      = 7'd79;
   localparam logic [7:0] PAD_MARK        = 8'h80;

   state_type         state_ff, state_in;
   logic [511:0]      win_ff, win_in;
   logic [4:0][31:0]  chain_ff, chain_in;
   logic [4:0][31:0]  var_ff, var_in;
   logic [5:0]        nbytes_ff, nbytes_in;
   logic [60:0]       count_ff, count_in;
   logic [63:0]       len_ff, len_in;
   logic [6:0]        round_ff, round_in;
   logic              fin_ff, fin_in;
   logic              pad_first_ff, pad_first_in;
   logic              len_phase_ff, len_phase_in;
   logic              out_pend_ff, out_pend_in;
   logic [2:0]        out_idx_ff, out_idx_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              push_en;
   logic [7:0]        push_byte;
   logic [31:0]       w0, w2, w8, w13, sched_new;
   logic [31:0]       ra, rb, rc, rd, re;
   logic [31:0]       f_val, k_val, tmp;

   assign w0  = win_ff[511 -: 32];
   assign w2  = win_ff[511 - 32*2 -: 32];
   assign w8  = win_ff[511 - 32*8 -: 32];
   assign w13 = win_ff[511 - 32*13 -: 32];
   assign sched_new = {w13[30:0] ^ w8[30:0] ^ w2[30:0] ^ w0[30:0],
                       w13[31] ^ w8[31] ^ w2[31] ^ w0[31]};

   assign ra = var_ff[0];
   assign rb = var_ff[1];
   assign rc = var_ff[2];
   assign rd = var_ff[3];
   assign re = var_ff[4];

   always_comb begin
      if (round_ff < 7'd20) begin
         f_val = ((rc ^ rd) & rb) ^ rd;
         k_val = 32'h5a827999;
      end else if (round_ff < 7'd40) begin
         f_val = rb ^ rc ^ rd;
         k_val = 32'h6ed9eba1;
      end else if (round_ff < 7'd60) begin
         f_val = (rb & rc) | (rd & (rb | rc));
         k_val = 32'h8f1bbcdc;
      end else begin
         f_val = rb ^ rc ^ rd;
         k_val = 32'hca62c1d6;
      end
   end

   assign tmp = {ra[26:0], ra[31:27]} + f_val + re + w0 + k_val;

   assign deq_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data.digest_word = chain_ff[out_idx_ff];
   assign rsp_data.word_index  = out_idx_ff;
   assign rsp_data.last_word   = (out_idx_ff == LAST_INDEX);

   always_comb begin
      state_in     = state_ff;
      win_in       = win_ff;
      chain_in     = chain_ff;
      var_in       = var_ff;
      nbytes_in    = nbytes_ff;
      count_in     = count_ff;
      len_in       = len_ff;
      round_in     = round_ff;
      fin_in       = fin_ff;
      pad_first_in = pad_first_ff;
      len_phase_in = len_phase_ff;
      out_pend_in  = out_pend_ff;
      out_idx_in   = out_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      push_en      = 1'b0;
      push_byte    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (deq_valid) begin
               if (deq_data.kind == KIND_APPEND) begin
                  push_en   = 1'b1;
                  push_byte = deq_data.data_byte;
               end else begin
                  len_in       = {count_ff, 3'b000};
                  fin_in       = 1'b1;
                  pad_first_in = 1'b1;
                  len_phase_in = 1'b0;
                  state_in     = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            push_en = 1'b1;
            if (pad_first_ff) begin
               push_byte    = PAD_MARK;
               pad_first_in = 1'b0;
            end else if (!len_phase_ff && nbytes_ff != LENGTH_OFFSET) begin
               push_byte = '0;
            end else begin
               push_byte    = len_ff[63:56];
               len_in       = {len_ff[55:0], 8'h00};
               len_phase_in = 1'b1;
               if (nbytes_ff == BLOCK_LAST_BYTE) begin
                  out_pend_in = 1'b1;
               end
            end
         end
         ST_ROUND: begin
            var_in[0] = tmp;
            var_in[1] = ra;
            var_in[2] = {rb[1:0], rb[31:2]};
            var_in[3] = rc;
            var_in[4] = rd;
            win_in    = {win_ff[479:0], sched_new};
            round_in  = round_ff + 1'b1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < 5; i++) begin
               chain_in[i] = chain_ff[i] + var_ff[i];
            end
            round_in = '0;
            if (out_pend_ff) begin
               state_in     = ST_OUT;
               out_idx_in   = '0;
               rsp_valid_in = 1'b1;
            end else if (fin_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (out_idx_ff == LAST_INDEX) begin
                  chain_in     = IV_WORDS;
                  nbytes_in    = '0;
                  count_in     = '0;
                  fin_in       = 1'b0;
                  len_phase_in = 1'b0;
                  out_pend_in  = 1'b0;
                  out_idx_in   = '0;
                  rsp_valid_in = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  out_idx_in = out_idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (push_en) begin
         win_in    = {win_ff[503:0], push_byte};
         nbytes_in = nbytes_ff + 1'b1;
         count_in  = count_ff + 1'b1;
         if (nbytes_ff == BLOCK_LAST_BYTE) begin
            state_in = ST_ROUND;
            round_in = '0;
            var_in   = chain_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chain_ff     <= IV_WORDS;
         nbytes_ff    <= '0;
         count_ff     <= '0;
         round_ff     <= '0;
         fin_ff       <= 1'b0;
         pad_first_ff <= 1'b0;
         len_phase_ff <= 1'b0;
         out_pend_ff  <= 1'b0;
         out_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chain_ff     <= chain_in;
         nbytes_ff    <= nbytes_in;
         count_ff     <= count_in;
         round_ff     <= round_in;
         fin_ff       <= fin_in;
         pad_first_ff <= pad_first_in;
         len_phase_ff <= len_phase_in;
         out_pend_ff  <= out_pend_in;
         out_idx_ff   <= out_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      win_ff <= win_in;
      var_ff <= var_in;
      len_ff <= len_in;
   end

endmodule

@@ rtl/sha1_message_digest_unit.sv @@
// SHA-1 digest of a byte stream: request queue feeding the hash core.
// An append request waits in the queue until the core takes it; each 64th byte starts
// 80 rounds, one per cycle, plus the chaining-word add, and no byte leaves the queue meanwhile.
// Finish: 9 to 72 padding bytes at one per cycle, one or two compressions, then five
// digest words, one per cycle while rsp_ready is high.
// Reset is synchronous: clears control, loads the initial chaining words; buffer not cleared.
`timescale 1ns / 1ps
module sha1_message_digest_unit
   import smd_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  smd_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output smd_rsp_type rsp_data
);

   logic        deq_valid;
   logic        deq_ready;
   smd_req_type deq_data;

   smd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .deq_valid (deq_valid),
      .deq_ready (deq_ready),
      .deq_data  (deq_data)
   );

   smd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .deq_valid (deq_valid),
      .deq_ready (deq_ready),
      .deq_data  (deq_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/smd_checker.sv @@
// Port-level checks for the SHA-1 message digest unit, bound to the top level.
`timescale 1ns / 1ps
module smd_checker
   import smd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input smd_rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("digest word changed while stalled");

   a_word_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_word |=>
         rsp_valid && (rsp_data.word_index == $past(rsp_data.word_index) + 3'd1))
      else $error("digest words not back to back in order");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_word == (rsp_data.word_index == LAST_INDEX)))
      else $error("last word flag does not match word index");

   a_after_reset: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> req_ready && !rsp_valid)
      else $error("unit not empty after reset");

endmodule

bind sha1_message_digest_unit smd_checker u_smd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
